// File: rtl/hist_pkg.sv
// Shared types and constants for the gray-level histogram block.
// Used by hist_front, hist_fifo, hist_back and the top level; depends on nothing.
package hist_pkg;

    localparam int PIX_W      = 8;
    localparam int IDX_W      = 8;
    localparam int OP_W       = 2;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_CNT_W  = 20;

    // Entries in the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR = 2'd2;

    localparam logic [PIX_W-1:0] MIN_RESET = 8'd0;
    localparam logic [PIX_W-1:0] MAX_RESET = 8'd255;
    localparam logic [THR_W-1:0] THR_RESET = 9'd128;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INCR,
        ACT_READ,
        ACT_CLEAR
    } t_act;

    typedef struct packed {
        t_act             act;
        logic [IDX_W-1:0] idx;
        logic             thr_bit;
        logic             err;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_FETCH,
        BS_EXEC
    } t_bstate;

endpackage

// File: rtl/hist_front.sv
// Front end: configuration registers and classification of incoming transactions.
// Depends on hist_pkg; feeds commands into hist_fifo.
module hist_front #(
    parameter int NUM_BINS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [hist_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hist_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [hist_pkg::OP_W-1:0]          i_operation,
    input  logic [hist_pkg::PIX_W-1:0]         i_pixel_value,
    input  logic [hist_pkg::IDX_W-1:0]         i_bin_index,
    input  logic                               i_full,
    input  logic                               i_busy,
    output logic                               o_push,
    output hist_pkg::t_cmd                     o_cmd
);

    logic [hist_pkg::PIX_W-1:0] r_min;
    logic [hist_pkg::PIX_W-1:0] r_max;
    logic [hist_pkg::THR_W-1:0] r_thr;

    logic pix_in_bins;
    logic idx_in_bins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= hist_pkg::MIN_RESET;
            r_max <= hist_pkg::MAX_RESET;
            r_thr <= hist_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hist_pkg::CFG_MIN: r_min <= i_cfg_data[hist_pkg::PIX_W-1:0];
                hist_pkg::CFG_MAX: r_max <= i_cfg_data[hist_pkg::PIX_W-1:0];
                hist_pkg::CFG_THR: r_thr <= i_cfg_data[hist_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_ready     = !i_full && !i_busy;
    assign o_push      = i_valid && o_ready;
    assign pix_in_bins = 32'(i_pixel_value) < 32'(NUM_BINS);
    assign idx_in_bins = 32'(i_bin_index) < 32'(NUM_BINS);

    always_comb begin
        o_cmd.act     = hist_pkg::ACT_NONE;
        o_cmd.idx     = i_bin_index;
        o_cmd.thr_bit = 1'b0;
        o_cmd.err     = 1'b0;
        case (i_operation)
            hist_pkg::OP_ACCUM: begin
                o_cmd.idx     = i_pixel_value;
                o_cmd.thr_bit = {1'b0, i_pixel_value} >= r_thr;
                if (i_pixel_value < r_min || i_pixel_value > r_max || !pix_in_bins) begin
                    o_cmd.err = 1'b1;
                end else begin
                    o_cmd.act = hist_pkg::ACT_INCR;
                end
            end
            hist_pkg::OP_READ: begin
                if (idx_in_bins) begin
                    o_cmd.act = hist_pkg::ACT_READ;
                end else begin
                    o_cmd.err = 1'b1;
                end
            end
            hist_pkg::OP_CLEAR: begin
                if (idx_in_bins) begin
                    o_cmd.act = hist_pkg::ACT_CLEAR;
                end else begin
                    o_cmd.err = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/hist_fifo.sv
// Short command queue that decouples the front end from the bin store.
// Depends on hist_pkg for the command type and depth.
module hist_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hist_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output hist_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (hist_pkg::QUEUE_DEPTH > 1) ? $clog2(hist_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hist_pkg::QUEUE_DEPTH + 1);

    hist_pkg::t_cmd   r_q [hist_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = r_count == CNT_W'(hist_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_q[r_rptr];

endmodule

// File: rtl/hist_back.sv
// Back end: bin store with read-modify-write sequencer, clearing sweep and result register.
// Depends on hist_pkg; takes commands from hist_fifo.
module hist_back #(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  hist_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_busy,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_threshold_bit,
    output logic                             o_range_error,
    output logic [hist_pkg::OUT_CNT_W-1:0]   o_bin_count
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    logic [COUNT_BITS-1:0] r_bins [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rd_data;

    hist_pkg::t_bstate r_state;
    hist_pkg::t_bstate n_state;
    hist_pkg::t_cmd    r_cmd;
    logic [AW-1:0]     r_clr_addr;

    logic                         r_out_valid;
    logic                         r_out_thr;
    logic                         r_out_err;
    logic [hist_pkg::OUT_CNT_W-1:0] r_out_cnt;

    logic                  exec_fire;
    logic                  mem_re;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  saturated;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hist_pkg::BS_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = hist_pkg::BS_FETCH;
                end
            end
            hist_pkg::BS_FETCH: begin
                if (i_cmd_valid) begin
                    n_state = hist_pkg::BS_EXEC;
                end
            end
            hist_pkg::BS_EXEC: begin
                if (exec_fire) begin
                    n_state = hist_pkg::BS_FETCH;
                end
            end
            default: n_state = hist_pkg::BS_FETCH;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        saturated = r_rd_data == {COUNT_BITS{1'b1}};
        exec_fire = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_cmd.idx);
        mem_wdata = '0;
        case (r_state)
            hist_pkg::BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            hist_pkg::BS_FETCH: begin
                mem_re = i_cmd_valid;
            end
            hist_pkg::BS_EXEC: begin
                exec_fire = !r_out_valid || i_ready;
                if (r_cmd.act == hist_pkg::ACT_INCR) begin
                    mem_we    = exec_fire && !saturated;
                    mem_wdata = r_rd_data + 1'b1;
                end else if (r_cmd.act == hist_pkg::ACT_CLEAR) begin
                    mem_we = exec_fire;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hist_pkg::BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hist_pkg::BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_cmd <= i_cmd;
        end
        if (exec_fire) begin
            r_out_thr <= r_cmd.thr_bit;
            r_out_err <= r_cmd.err;
            r_out_cnt <= (r_cmd.act == hist_pkg::ACT_READ) ?
                         hist_pkg::OUT_CNT_W'(r_rd_data) : '0;
        end
    end

    // Bin store: one read port, one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_bins[AW'(i_cmd.idx)];
        end
        if (mem_we) begin
            r_bins[mem_waddr] <= mem_wdata;
        end
    end

    assign o_pop           = mem_re;
    assign o_busy          = r_state == hist_pkg::BS_CLEAR;
    assign o_valid         = r_out_valid;
    assign o_threshold_bit = r_out_thr;
    assign o_range_error   = r_out_err;
    assign o_bin_count     = r_out_cnt;

endmodule

// File: rtl/pixel_histogram_with_threshold.sv
// Gray-level histogram with threshold bit: front end, command queue, bin store back end.
// A result passes through the queue, the bin fetch and the result register before it is valid.
// The back end fetches a bin and then writes it back before its next fetch, so it takes no new
// transaction while one is in progress; the queue lets the front accept while a result waits.
// Reset: synchronous, active low; afterwards a sweep through all NUM_BINS bins zeroes them, during
// which o_ready stays low (configuration writes are still taken).
module pixel_histogram_with_threshold #(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hist_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hist_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hist_pkg::OP_W-1:0]        i_operation,
    input  logic [hist_pkg::PIX_W-1:0]       i_pixel_value,
    input  logic [hist_pkg::IDX_W-1:0]       i_bin_index,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_threshold_bit,
    output logic                             o_range_error,
    output logic [hist_pkg::OUT_CNT_W-1:0]   o_bin_count
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_busy;
    logic           w_q_valid;
    hist_pkg::t_cmd w_front_cmd;
    hist_pkg::t_cmd w_q_cmd;

    hist_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_pixel_value (i_pixel_value),
        .i_bin_index   (i_bin_index),
        .i_full        (w_full),
        .i_busy        (w_busy),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    hist_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    hist_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_pop           (w_pop),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_threshold_bit (o_threshold_bit),
        .o_range_error   (o_range_error),
        .o_bin_count     (o_bin_count)
    );

    // No transaction may enter while the bins are still being zeroed.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_push)
        else $error("input transaction accepted during clearing sweep");

    // A refused transaction never reports a count.
    a_err_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_bin_count == '0))
        else $error("range error reported with non-zero count");

    // The threshold bit only comes with an accumulate, which carries no count.
    a_thr_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_threshold_bit) |-> (o_bin_count == '0))
        else $error("threshold bit reported together with a count");

    // The queue is never popped when empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command queue popped while empty");

endmodule

// File: verif/pixel_histogram_with_threshold_checker.sv
// Checker for the gray-level histogram block: watches both channels and the register port.
// It predicts each result from its own copy of the bin store and compares field by field.
// Depends on hist_pkg for widths, operation codes and register indexes.
module pixel_histogram_with_threshold_checker
    import hist_pkg::*;
#(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  logic [IDX_W-1:0]      i_bin_index,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_threshold_bit,
    input  logic                  i_range_error,
    input  logic [OUT_CNT_W-1:0]  i_bin_count,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 thr_bit;
        logic                 err;
        logic [OUT_CNT_W-1:0] count;
    } t_bin_result;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] bin_counts [NUM_BINS];
    logic [PIX_W-1:0]      min_level;
    logic [PIX_W-1:0]      max_level;
    logic [THR_W-1:0]      thr_level;
    t_bin_result           awaited_results [$];
    int                    fail_total = 0;
    int                    pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Applies one transaction to the bin store and returns the result it must produce.
    function t_bin_result apply_histogram_op(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                                             logic [IDX_W-1:0] idx);
        t_bin_result res;
        res = '0;
        case (op)
            OP_ACCUM: begin
                res.thr_bit = ({1'b0, pix} >= thr_level);
                if (pix < min_level || pix > max_level || int'(pix) >= NUM_BINS) begin
                    res.err = 1'b1;
                end else if (bin_counts[pix] != COUNT_MAX) begin
                    bin_counts[pix] = bin_counts[pix] + 1'b1;
                end
            end
            OP_READ: begin
                if (int'(idx) < NUM_BINS) begin
                    res.count = OUT_CNT_W'(bin_counts[idx]);
                end else begin
                    res.err = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (int'(idx) < NUM_BINS) begin
                    bin_counts[idx] = '0;
                end else begin
                    res.err = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        fail_total = fail_total + 1;
    endtask

    always @(posedge i_clk) begin
        t_bin_result want;
        if (!i_rst_n) begin
            foreach (bin_counts[b]) begin
                bin_counts[b] = '0;
            end
            min_level = MIN_RESET;
            max_level = MAX_RESET;
            thr_level = THR_RESET;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN: min_level = i_cfg_data[PIX_W-1:0];
                    CFG_MAX: max_level = i_cfg_data[PIX_W-1:0];
                    CFG_THR: thr_level = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            // A result can never belong to the transaction accepted at the same edge,
            // so the oldest expectation is taken before the new one is queued.
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with none awaited", 32'(i_bin_count), 32'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_threshold_bit !== want.thr_bit) begin
                        report_mismatch("threshold_bit", 32'(i_threshold_bit), 32'(want.thr_bit));
                    end
                    if (i_range_error !== want.err) begin
                        report_mismatch("range_error", 32'(i_range_error), 32'(want.err));
                    end
                    if (i_bin_count !== want.count) begin
                        report_mismatch("bin_count", 32'(i_bin_count), 32'(want.count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(apply_histogram_op(i_operation, i_pixel_value,
                                                             i_bin_index));
            end
        end
        pending_total = awaited_results.size();
    end

endmodule

// File: verif/pixel_histogram_with_threshold_test.sv
// Top of the histogram testbench: clock, reset, stimulus and the verdict.
// Depends on hist_pkg, the block pixel_histogram_with_threshold and the checker module.
module pixel_histogram_with_threshold_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hist_pkg::*;

    localparam int NUM_BINS     = 256;
    localparam int COUNT_BITS   = 20;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 130;

    // Codes the block defines no meaning for.
    localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic [OP_W-1:0]       i_operation = '0;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic [IDX_W-1:0]      i_bin_index = '0;
    logic                  i_ready = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_threshold_bit;
    logic                  o_range_error;
    logic [OUT_CNT_W-1:0]  o_bin_count;

    int                    fail_count;
    int                    pending;
    t_rx_mode              rx_mode = RX_OPEN;
    int                    rx_left = 0;
    int                    rx_tick = 0;
    logic [PIX_W-1:0]      hot_base = '0;
    logic [PIX_W-1:0]      lo;
    logic [PIX_W-1:0]      hi;
    logic [THR_W-1:0]      thr;
    int                    burst_left;

    pixel_histogram_with_threshold #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_pixel_value   (i_pixel_value),
        .i_bin_index     (i_bin_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_threshold_bit (o_threshold_bit),
        .o_range_error   (o_range_error),
        .o_bin_count     (o_bin_count)
    );

    pixel_histogram_with_threshold_checker #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_operation     (i_operation),
        .i_pixel_value   (i_pixel_value),
        .i_bin_index     (i_bin_index),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_threshold_bit (o_threshold_bit),
        .i_range_error   (o_range_error),
        .i_bin_count     (o_bin_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    // The result side switches at random among four stall modes: open, coin toss, sparse and periodic.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:     i_ready <= 1'b1;
            RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_ready <= ((rx_tick % 5) < 3);
            default:     i_ready <= 1'b1;
        endcase
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix, logic [IDX_W-1:0] idx);
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_pixel_value <= pix;
        i_bin_index   <= idx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every awaited result has come and the pipeline is quiet.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Pixels are drawn near hot_base half the time and bins six times in ten, so that counts build up
    // and back-to-back updates of one bin are frequent.
    task automatic send_random();
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] idx;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            op = OP_ACCUM;
        end else if (pick < 80) begin
            op = OP_READ;
        end else if (pick < 93) begin
            op = OP_CLEAR;
        end else begin
            op = OP_SPARE;
        end
        pix = $urandom_range(0, 1) ? hot_base + 8'($urandom_range(0, 5))
                                   : 8'($urandom_range(0, 255));
        idx = ($urandom_range(0, 9) < 6) ? hot_base + 8'($urandom_range(0, 5))
                                         : 8'($urandom_range(0, 255));
        send_item(op, pix, idx);
    endtask

    initial begin
        #2_000_000;
        $display("pixel_histogram_with_threshold_test: FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default registers: edges of the pixel range, the threshold boundary and
        // repeated updates of one bin followed at once by a read of it.
        send_item(OP_ACCUM, 8'd0, 8'($urandom_range(0, 255)));
        send_item(OP_ACCUM, 8'd255, 8'($urandom_range(0, 255)));
        send_item(OP_ACCUM, 8'd128, 8'($urandom_range(0, 255)));
        send_item(OP_ACCUM, 8'd127, 8'($urandom_range(0, 255)));
        repeat (4) send_item(OP_ACCUM, 8'd77, 8'd0);
        send_item(OP_READ, 8'd255, 8'd77);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_CLEAR, 8'd77, 8'd77);
        send_item(OP_READ, 8'd77, 8'd77);
        send_item(OP_READ, 8'd0, 8'd200);
        send_item(OP_SPARE, 8'd255, 8'd255);
        send_item(OP_CLEAR, 8'd0, 8'd255);
        send_item(OP_READ, 8'd0, 8'd255);

        // Narrow window with a zero threshold; bit 8 of the data is ignored for min.
        wait_drained();
        write_reg(CFG_MIN, 9'h10A);
        write_reg(CFG_MAX, 9'd20);
        write_reg(CFG_THR, 9'd0);
        send_item(OP_ACCUM, 8'd9, 8'd0);
        send_item(OP_ACCUM, 8'd10, 8'd0);
        send_item(OP_ACCUM, 8'd20, 8'd0);
        send_item(OP_ACCUM, 8'd21, 8'd0);
        send_item(OP_READ, 8'd0, 8'd10);

        // Minimum above maximum refuses every pixel; a threshold above 255 is never reached.
        wait_drained();
        write_reg(CFG_MIN, 9'd200);
        write_reg(CFG_MAX, 9'd100);
        write_reg(CFG_THR, 9'd256);
        send_item(OP_ACCUM, 8'd150, 8'd0);
        send_item(OP_ACCUM, 8'd255, 8'd0);
        wait_drained();
        write_reg(CFG_THR, 9'h1FF);
        write_reg(CFG_SPARE, 9'($urandom_range(0, 511)));
        send_item(OP_ACCUM, 8'd255, 8'd0);
        send_item(OP_READ, 8'd0, 8'd150);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin lo = 8'd0;   hi = 8'd255; thr = 9'd128; end
                1: begin lo = 8'd0;   hi = 8'd0;   thr = 9'd0;   end
                2: begin lo = 8'd255; hi = 8'd255; thr = 9'd255; end
                3: begin
                    lo  = 8'($urandom_range(0, 100));
                    hi  = 8'($urandom_range(150, 255));
                    thr = 9'($urandom_range(0, 256));
                end
                4: begin lo = 8'd255; hi = 8'd0;   thr = 9'd256; end
                5: begin
                    lo  = 8'($urandom_range(0, 255));
                    hi  = 8'($urandom_range(0, 255));
                    thr = 9'h1FF;
                end
                default: begin lo = 8'd1; hi = 8'd254; thr = 9'd1; end
            endcase
            write_reg(CFG_MIN, {1'($urandom_range(0, 1)), lo});
            write_reg(CFG_MAX, {1'($urandom_range(0, 1)), hi});
            write_reg(CFG_THR, thr);
            hot_base   = (lo <= hi) ? lo + 8'($urandom_range(0, hi - lo))
                                    : 8'($urandom_range(0, 255));
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                    burst_left = $urandom_range(1, 40);
                end
                if ($urandom_range(0, 79) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("pixel_histogram_with_threshold_test: PASS");
        end else begin
            $display("pixel_histogram_with_threshold_test: FAIL");
        end
        $finish;
    end

endmodule
